// ----- design/fsd_pkg.sv -----
`timescale 1ns / 1ps

package fsd_pkg;

  // Sizing
  localparam int STAGES      = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam int STAGE_W = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int IDX_W   = $clog2(STAGES + 1);
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QADDR_W = (STAGES * QUEUE_DEPTH > 1) ? $clog2(STAGES * QUEUE_DEPTH) : 1;

  // Field and register widths
  localparam int FRAME_W    = 8;
  localparam int ACTION_W   = 2;
  localparam int TGT_ID_W   = 4;
  localparam int WARN_W     = 2;
  localparam int COUNT_W    = 4;
  localparam int POLICY_W   = 16;
  localparam int TARGET_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_POLICIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_TARGETS  = 2'd2;

  // Stage policies
  localparam logic [1:0] POL_DROP        = 2'd0;
  localparam logic [1:0] POL_DROP_OLDEST = 2'd1;
  localparam logic [1:0] POL_WAIT        = 2'd2;
  localparam logic [1:0] POL_NO_REPLY    = 2'd3;

  // Result actions
  localparam logic [ACTION_W-1:0] ACT_DISPATCH = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_WARN     = 2'd2;

  // Warning codes
  localparam logic [WARN_W-1:0] W_NONE     = 2'd0;
  localparam logic [WARN_W-1:0] W_CHAIN    = 2'd1;
  localparam logic [WARN_W-1:0] W_UNKNOWN  = 2'd2;
  localparam logic [WARN_W-1:0] W_OVERFLOW = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_POP,
    ST_SEND,
    ST_DROP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic match;
    logic pop_use;
    logic send;
    logic drop_use;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_return;
    logic found;
    logic queued;
    logic send_pop;
  } dp_status_t;

endpackage

// ----- design/fsd_ctrl.sv -----
`timescale 1ns / 1ps

module fsd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  fsd_pkg::dp_status_t  sts,
  output fsd_pkg::dp_cmd_t     ctl
);
  import fsd_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_MATCH;
      end
      ST_MATCH: begin
        if (!sts.is_return) state_next = ST_SEND;
        else if (!sts.found) state_next = ST_IDLE;
        else if (sts.queued) state_next = ST_POP;
        else state_next = ST_SEND;
      end
      ST_POP: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        state_next = sts.send_pop ? ST_DROP : ST_IDLE;
      end
      ST_DROP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      ST_MATCH: ctl.match    = 1'b1;
      ST_POP:   ctl.pop_use  = 1'b1;
      ST_SEND:  ctl.send     = 1'b1;
      ST_DROP:  ctl.drop_use = 1'b1;
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // The pop step is only entered from the match step
  a_pop_after_match: assert property (@(posedge clk) disable iff (rst)
    state == ST_POP |-> $past(state) == ST_MATCH)
    else $error("pop step not preceded by match step");

  // Drop-oldest finish always ends the item
  a_drop_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_DROP |=> state == ST_IDLE)
    else $error("drop step did not return to idle");

  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ctl))
    else $error("overlapping datapath commands");

endmodule

// ----- design/fsd_datapath.sv -----
`timescale 1ns / 1ps

module fsd_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  fsd_pkg::dp_cmd_t                 ctl,
  output fsd_pkg::dp_status_t              sts,
  input  logic                             cmd,
  input  logic [fsd_pkg::FRAME_W-1:0]      frame_id,
  input  logic                             cfg_write,
  input  logic [fsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             result_valid,
  output logic [fsd_pkg::ACTION_W-1:0]     action,
  output logic [fsd_pkg::TGT_ID_W-1:0]     target,
  output logic [fsd_pkg::FRAME_W-1:0]      out_frame,
  output logic [fsd_pkg::WARN_W-1:0]       warning,
  output logic                             last
);
  import fsd_pkg::*;

  typedef enum logic [2:0] {
    SO_WARN_CHAIN,
    SO_RELEASE,
    SO_DROP_OLDEST,
    SO_PUSH,
    SO_OVERFLOW,
    SO_DISPATCH
  } send_out_t;

  // Configuration
  logic [COUNT_W-1:0]  stage_count;
  logic [POLICY_W-1:0] stage_policies;
  logic [TARGET_W-1:0] stage_targets;

  // Stage and queue state
  logic [STAGES-1:0]  stage_busy;
  logic [FRAME_W-1:0] stage_frame [STAGES];
  logic [FILL_W-1:0]  queue_fill  [STAGES];
  logic [QPTR_W-1:0]  queue_head  [STAGES];
  logic [FRAME_W-1:0] queue_mem   [STAGES * QUEUE_DEPTH];
  logic [FRAME_W-1:0] mem_rdata;

  // Item registers
  logic               cur_cmd;
  logic [FRAME_W-1:0] cur_frame;
  logic [IDX_W-1:0]   idx;
  logic [STAGE_W-1:0] pop_stage;

  // Combinational
  logic [IDX_W-1:0]   eff_n;
  logic               chain_ok;
  logic               found;
  logic [STAGE_W-1:0] found_idx;
  logic [STAGE_W-1:0] q_sel;
  logic [STAGE_W-1:0] s_idx;
  logic [FILL_W-1:0]  sel_fill;
  logic [QPTR_W-1:0]  sel_head;
  logic               sel_full;
  logic [FILL_W:0]    slot_sum;
  logic [QPTR_W-1:0]  push_slot;
  logic [QPTR_W-1:0]  head_inc;
  send_out_t          outcome;
  logic               cfg_hit;
  logic               do_pop;
  logic               do_push;
  logic               ret_hit;
  logic               fill_over;

  logic                emit_en;
  logic [ACTION_W-1:0] emit_action;
  logic [TGT_ID_W-1:0] emit_target;
  logic [FRAME_W-1:0]  emit_frame;
  logic [WARN_W-1:0]   emit_warn;
  logic                emit_last;

  function automatic logic [1:0] policy_at(input logic [POLICY_W-1:0] pols,
                                           input logic [STAGE_W-1:0] s);
    logic [POLICY_W-1:0] sh;
    sh = pols >> {s, 1'b0};
    return sh[1:0];
  endfunction

  function automatic logic [TGT_ID_W-1:0] target_at(input logic [TARGET_W-1:0] tgts,
                                                    input logic [STAGE_W-1:0] s);
    logic [TARGET_W-1:0] sh;
    sh = tgts >> {s, 2'b00};
    return sh[TGT_ID_W-1:0];
  endfunction

  function automatic logic [QADDR_W-1:0] q_addr(input logic [STAGE_W-1:0] s,
                                                input logic [QPTR_W-1:0] slot);
    return QADDR_W'(s) * QADDR_W'(QUEUE_DEPTH) + QADDR_W'(slot);
  endfunction

  // Effective stage count and chain check
  always_comb begin
    if ({1'b0, stage_count} > (COUNT_W + 1)'(STAGES)) eff_n = IDX_W'(STAGES);
    else eff_n = IDX_W'(stage_count);
    chain_ok = (eff_n != '0);
    for (int i = 0; i < STAGES; i++) begin
      if (IDX_W'(i) < eff_n && policy_at(stage_policies, STAGE_W'(i)) == POL_NO_REPLY &&
          IDX_W'(i + 1) != eff_n) chain_ok = 1'b0;
    end
  end

  // Returned frame lookup, lowest stage wins
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = STAGES - 1; i >= 0; i--) begin
      if (IDX_W'(i) < eff_n && stage_busy[i] && stage_frame[i] == cur_frame) begin
        found     = 1'b1;
        found_idx = STAGE_W'(i);
      end
    end
  end

  // Queue pointers of the selected stage
  always_comb begin
    s_idx    = idx[STAGE_W-1:0];
    q_sel    = ctl.match ? found_idx : s_idx;
    sel_fill = queue_fill[q_sel];
    sel_head = queue_head[q_sel];
    sel_full = (sel_fill == FILL_W'(QUEUE_DEPTH));
    slot_sum = (FILL_W + 1)'(sel_head) + (FILL_W + 1)'(sel_fill);
    if (slot_sum >= (FILL_W + 1)'(QUEUE_DEPTH))
      push_slot = QPTR_W'(slot_sum - (FILL_W + 1)'(QUEUE_DEPTH));
    else
      push_slot = QPTR_W'(slot_sum);
    if (sel_head == QPTR_W'(QUEUE_DEPTH - 1)) head_inc = '0;
    else head_inc = sel_head + QPTR_W'(1);
  end

  // Send decision for stage idx
  always_comb begin
    if (!chain_ok) outcome = SO_WARN_CHAIN;
    else if (idx >= eff_n) outcome = SO_RELEASE;
    else if (stage_busy[s_idx]) begin
      case (policy_at(stage_policies, s_idx))
        POL_DROP:        outcome = SO_RELEASE;
        POL_DROP_OLDEST: outcome = sel_full ? SO_DROP_OLDEST : SO_PUSH;
        POL_WAIT:        outcome = sel_full ? SO_OVERFLOW : SO_PUSH;
        default:         outcome = SO_DISPATCH;
      endcase
    end else outcome = SO_DISPATCH;
  end

  assign ret_hit = ctl.match && cur_cmd && found;
  assign do_pop  = (ret_hit && sel_fill != '0) || (ctl.send && outcome == SO_DROP_OLDEST);
  assign do_push = (ctl.send && outcome == SO_PUSH) || ctl.drop_use;
  assign cfg_hit = cfg_write && (cfg_index == CFG_STAGE_COUNT ||
                   cfg_index == CFG_STAGE_POLICIES || cfg_index == CFG_STAGE_TARGETS);

  always_comb begin
    sts.is_return = cur_cmd;
    sts.found     = found;
    sts.queued    = (sel_fill != '0);
    sts.send_pop  = (outcome == SO_DROP_OLDEST);
  end

  // Result selection
  always_comb begin
    emit_en     = 1'b0;
    emit_action = ACT_RELEASE;
    emit_target = '0;
    emit_frame  = cur_frame;
    emit_warn   = W_NONE;
    emit_last   = 1'b1;
    if (ctl.match && cur_cmd && !found) begin
      emit_en   = 1'b1;
      emit_warn = W_UNKNOWN;
    end else if (ctl.pop_use) begin
      emit_en    = 1'b1;
      emit_frame = mem_rdata;
      emit_last  = (outcome == SO_PUSH);
      if (chain_ok) begin
        emit_action = ACT_DISPATCH;
        emit_target = target_at(stage_targets, pop_stage);
      end else begin
        emit_action = ACT_WARN;
        emit_warn   = W_CHAIN;
      end
    end else if (ctl.send) begin
      case (outcome)
        SO_WARN_CHAIN: begin
          emit_en     = 1'b1;
          emit_action = ACT_WARN;
          emit_warn   = W_CHAIN;
        end
        SO_RELEASE: emit_en = 1'b1;
        SO_OVERFLOW: begin
          emit_en   = 1'b1;
          emit_warn = W_OVERFLOW;
        end
        SO_DISPATCH: begin
          emit_en     = 1'b1;
          emit_action = ACT_DISPATCH;
          emit_target = target_at(stage_targets, s_idx);
        end
        default: emit_en = 1'b0;
      endcase
    end else if (ctl.drop_use) begin
      emit_en    = 1'b1;
      emit_frame = mem_rdata;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_count    <= '0;
      stage_policies <= '0;
      stage_targets  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_STAGE_COUNT:    stage_count    <= cfg_data[COUNT_W-1:0];
        CFG_STAGE_POLICIES: stage_policies <= cfg_data[POLICY_W-1:0];
        CFG_STAGE_TARGETS:  stage_targets  <= cfg_data[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage busy flags and queue pointers
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      stage_busy <= '0;
      for (int i = 0; i < STAGES; i++) begin
        queue_fill[i] <= '0;
        queue_head[i] <= '0;
      end
    end else begin
      if (ret_hit) stage_busy[found_idx] <= 1'b0;
      if (ctl.pop_use && chain_ok) stage_busy[pop_stage] <= 1'b1;
      if (ctl.send && outcome == SO_DISPATCH) stage_busy[s_idx] <= 1'b1;
      if (do_pop) begin
        queue_head[q_sel] <= head_inc;
        queue_fill[q_sel] <= sel_fill - FILL_W'(1);
      end else if (do_push) begin
        queue_fill[q_sel] <= sel_fill + FILL_W'(1);
      end
    end
  end

  // Held frame per stage
  always_ff @(posedge clk) begin
    if (ctl.pop_use && chain_ok) stage_frame[pop_stage] <= mem_rdata;
    if (ctl.send && outcome == SO_DISPATCH) stage_frame[s_idx] <= cur_frame;
  end

  // Queue storage, registered read
  always_ff @(posedge clk) begin
    if (do_push) queue_mem[q_addr(q_sel, push_slot)] <= cur_frame;
    if (do_pop) mem_rdata <= queue_mem[q_addr(q_sel, sel_head)];
  end

  // Item registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur_cmd   <= cmd;
      cur_frame <= frame_id;
      idx       <= '0;
    end else if (ret_hit) begin
      idx       <= IDX_W'(found_idx) + IDX_W'(1);
      pop_stage <= found_idx;
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit_en;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      action    <= emit_action;
      target    <= emit_target;
      out_frame <= emit_frame;
      warning   <= emit_warn;
      last      <= emit_last;
    end
  end

  always_comb begin
    fill_over = 1'b0;
    for (int i = 0; i < STAGES; i++) begin
      if (queue_fill[i] > FILL_W'(QUEUE_DEPTH)) fill_over = 1'b1;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    !fill_over)
    else $error("queue fill beyond depth");

  a_pop_claims_stage: assert property (@(posedge clk) disable iff (rst)
    ctl.pop_use && chain_ok && !cfg_write |=> stage_busy[$past(pop_stage)])
    else $error("dispatched queue head did not occupy its stage");

  a_dispatch_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && action == ACT_DISPATCH |-> warning == W_NONE)
    else $error("dispatch beat carries a warning");

endmodule

// ----- design/frame_stage_dispatcher.sv -----
`timescale 1ns / 1ps

// Frame stage dispatcher.
// Input channel: an item (cmd, frame_id) is taken at a rising edge with start
// high and busy low. cmd 0 is a new camera frame, cmd 1 a frame handed back
// by a stage.
// Result channel: each result beat is on action/target/out_frame/warning/last
// for exactly one cycle, marked by result_valid; the receiver cannot stall it.
// An item gives zero, one or two beats; last marks its final beat.
// Config port: cfg_write with cfg_index/cfg_data writes a register (0 stage
// count, 1 policies, 2 targets); any such write clears every
// stage's busy flag and queue. Write only while busy is low.
// Steps: an item passes the match step, then the send step. A returned frame
// that is unknown ends after match; one whose stage has a queued head takes a
// pop step between match and send; a full drop-oldest queue adds a drop step
// after send. busy stays high from the accepting edge until the item's last
// step. A popped head comes through the registered read of the queue memory,
// and each beat is registered from the step that makes it.
// Reset: synchronous; clears config, busy flags and queue fills, no sweep.

module frame_stage_dispatcher (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cmd,
  input  logic [fsd_pkg::FRAME_W-1:0]      frame_id,
  input  logic                             cfg_write,
  input  logic [fsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             result_valid,
  output logic [fsd_pkg::ACTION_W-1:0]     action,
  output logic [fsd_pkg::TGT_ID_W-1:0]     target,
  output logic [fsd_pkg::FRAME_W-1:0]      out_frame,
  output logic [fsd_pkg::WARN_W-1:0]       warning,
  output logic                             last
);
  import fsd_pkg::*;

  dp_cmd_t    ctl;
  dp_status_t sts;

  // Step sequencer
  fsd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Stage state, queues and result register
  fsd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cmd          (cmd),
    .frame_id     (frame_id),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .action       (action),
    .target       (target),
    .out_frame    (out_frame),
    .warning      (warning),
    .last         (last)
  );

endmodule

// ----- tb/sv/tb_frame_stage_dispatcher.sv -----
`timescale 1ns / 1ps

module tb_frame_stage_dispatcher;
  import fsd_pkg::*;

  // Input commands
  localparam logic CMD_NEW    = 1'b0;
  localparam logic CMD_RETURN = 1'b1;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [TGT_ID_W-1:0] tgt;
    logic [FRAME_W-1:0]  frm;
    logic [WARN_W-1:0]   warn;
    logic                fin;
  } beat_t;

  // One step of the directed plan: a frame event or a register setup
  typedef struct packed {
    logic                is_setup;
    logic [3:0]          mask;
    logic                cmd;
    logic [FRAME_W-1:0]  frm;
    logic [COUNT_W-1:0]  cnt;
    logic [POLICY_W-1:0] pol;
    logic [TARGET_W-1:0] tgt;
    logic                typed;
    beat_t               want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  cmd;
  logic [FRAME_W-1:0]    frame_id;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  result_valid;
  logic [ACTION_W-1:0]   action;
  logic [TGT_ID_W-1:0]   target;
  logic [FRAME_W-1:0]    out_frame;
  logic [WARN_W-1:0]     warning;
  logic                  last;

  // Shadow of the dispatcher state
  logic [COUNT_W-1:0]    reg_count;
  logic [POLICY_W-1:0]   reg_policies;
  logic [TARGET_W-1:0]   reg_targets;
  logic                  chain_valid;
  logic                  slot_busy [STAGES];
  logic [FRAME_W-1:0]    slot_frame [STAGES];
  logic [FRAME_W-1:0]    fifo_mem [STAGES][QUEUE_DEPTH];
  int                    fifo_fill [STAGES];

  beat_t                 item_beats [$];
  beat_t                 pending_beats [$];
  plan_row_t             plan [$];

  int fail_count = 0;
  int n_events   = 0;
  int n_setups   = 0;
  int n_beats    = 0;
  int n_overflow = 0;
  int n_unknown  = 0;
  int n_chain    = 0;
  int n_two      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_stage_dispatcher i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .frame_id     (frame_id),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .action       (action),
    .target       (target),
    .out_frame    (out_frame),
    .warning      (warning),
    .last         (last)
  );

  // ---------------------------------------------------------------- predictor

  function automatic int live_stages();
    return (reg_count > STAGES) ? STAGES : int'(reg_count);
  endfunction

  function automatic void add_beat(logic [ACTION_W-1:0] a, logic [TGT_ID_W-1:0] t,
                                   logic [FRAME_W-1:0] f, logic [WARN_W-1:0] w);
    beat_t b;
    b.act  = a;
    b.tgt  = t;
    b.frm  = f;
    b.warn = w;
    b.fin  = 1'b0;
    item_beats.push_back(b);
  endfunction

  function automatic logic [FRAME_W-1:0] fifo_pop(int s);
    logic [FRAME_W-1:0] head;
    head = fifo_mem[s][0];
    for (int k = 0; k + 1 < QUEUE_DEPTH; k++) fifo_mem[s][k] = fifo_mem[s][k+1];
    if (fifo_fill[s] > 0) fifo_fill[s]--;
    return head;
  endfunction

  function automatic void fifo_push(int s, logic [FRAME_W-1:0] f);
    if (fifo_fill[s] < QUEUE_DEPTH) begin
      fifo_mem[s][fifo_fill[s]] = f;
      fifo_fill[s]++;
    end
  endfunction

  // Hand a frame to stage idx; past the last stage it is released
  function automatic void route_to_stage(int idx, logic [FRAME_W-1:0] f);
    if (!chain_valid) begin
      add_beat(ACT_WARN, '0, f, W_CHAIN);
      return;
    end
    if (idx >= live_stages()) begin
      add_beat(ACT_RELEASE, '0, f, W_NONE);
      return;
    end
    if (slot_busy[idx]) begin
      case (reg_policies[2*idx +: 2])
        POL_DROP: begin
          add_beat(ACT_RELEASE, '0, f, W_NONE);
          return;
        end
        POL_DROP_OLDEST: begin
          if (fifo_fill[idx] >= QUEUE_DEPTH) add_beat(ACT_RELEASE, '0, fifo_pop(idx), W_NONE);
          fifo_push(idx, f);
          return;
        end
        POL_WAIT: begin
          if (fifo_fill[idx] >= QUEUE_DEPTH) add_beat(ACT_RELEASE, '0, f, W_OVERFLOW);
          else fifo_push(idx, f);
          return;
        end
        default: ;  // no-reply stage: dispatch over the held frame
      endcase
    end
    slot_busy[idx]  = 1'b1;
    slot_frame[idx] = f;
    add_beat(ACT_DISPATCH, reg_targets[4*idx +: 4], f, W_NONE);
  endfunction

  // Expected beats of one frame event, left in item_beats
  function automatic void forecast_event(logic c, logic [FRAME_W-1:0] f);
    int n;
    int found;
    item_beats.delete();
    if (c == CMD_NEW) begin
      route_to_stage(0, f);
    end else begin
      n = live_stages();
      found = n;
      for (int i = 0; i < n; i++)
        if (slot_busy[i] && slot_frame[i] == f && found == n) found = i;
      if (found >= n) begin
        add_beat(ACT_RELEASE, '0, f, W_UNKNOWN);
      end else begin
        slot_busy[found] = 1'b0;
        if (fifo_fill[found] > 0) route_to_stage(found, fifo_pop(found));
        route_to_stage(found + 1, f);
      end
    end
    if (item_beats.size() > 0) item_beats[item_beats.size()-1].fin = 1'b1;
  endfunction

  // Register write: any known index rechecks the chain and empties all stages
  function automatic void store_setup(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int   n;
    logic ok;
    case (idx)
      CFG_STAGE_COUNT:    reg_count    = data[COUNT_W-1:0];
      CFG_STAGE_POLICIES: reg_policies = data[POLICY_W-1:0];
      CFG_STAGE_TARGETS:  reg_targets  = data[TARGET_W-1:0];
      default: return;
    endcase
    n  = live_stages();
    ok = (n > 0);
    for (int i = 0; i < n; i++)
      if (reg_policies[2*i +: 2] == POL_NO_REPLY && i + 1 != n) ok = 1'b0;
    chain_valid = ok;
    for (int i = 0; i < STAGES; i++) begin
      slot_busy[i] = 1'b0;
      fifo_fill[i] = 0;
    end
  endfunction

  // ---------------------------------------------------------------- directed plan

  function automatic void plan_item(logic c, logic [FRAME_W-1:0] f);
    plan_row_t r;
    r = '0;
    r.cmd = c;
    r.frm = f;
    plan.push_back(r);
  endfunction

  function automatic void plan_typed(logic c, logic [FRAME_W-1:0] f, logic [ACTION_W-1:0] a,
                                     logic [TGT_ID_W-1:0] t, logic [WARN_W-1:0] w);
    plan_row_t r;
    r = '0;
    r.cmd       = c;
    r.frm       = f;
    r.typed     = 1'b1;
    r.want.act  = a;
    r.want.tgt  = t;
    r.want.frm  = f;
    r.want.warn = w;
    r.want.fin  = 1'b1;
    plan.push_back(r);
  endfunction

  function automatic void plan_setup(logic [3:0] mask, logic [COUNT_W-1:0] cnt,
                                     logic [POLICY_W-1:0] pol, logic [TARGET_W-1:0] tgt);
    plan_row_t r;
    r = '0;
    r.is_setup = 1'b1;
    r.mask     = mask;
    r.cnt      = cnt;
    r.pol      = pol;
    r.tgt      = tgt;
    plan.push_back(r);
  endfunction

  // ---------------------------------------------------------------- drivers

  // Present one frame event and wait for the accepting edge
  task automatic issue_event(logic c, logic [FRAME_W-1:0] f, logic typed, beat_t want);
    start    <= 1'b1;
    cmd      <= c;
    frame_id <= f;
    @(posedge clk);
    while (busy) @(posedge clk);
    forecast_event(c, f);
    if (typed) pending_beats.push_back(want);
    else foreach (item_beats[k]) pending_beats.push_back(item_beats[k]);
    n_events++;
  endtask

  // Drain the block, then write the registers selected by mask
  task automatic program_chain(logic [3:0] mask, logic [COUNT_W-1:0] cnt,
                               logic [POLICY_W-1:0] pol, logic [TARGET_W-1:0] tgt);
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    // an event may still be in flight without a beat
    repeat (6) @(posedge clk);
    while (busy) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        idx = CFG_IDX_W'(i);
        case (idx)
          CFG_STAGE_COUNT:    data = CFG_DATA_W'(cnt);
          CFG_STAGE_POLICIES: data = CFG_DATA_W'(pol);
          CFG_STAGE_TARGETS:  data = CFG_DATA_W'(tgt);
          default:            data = $urandom();
        endcase
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        store_setup(idx, data);
      end
    end
    cfg_write <= 1'b0;
    n_setups++;
  endtask

  // ---------------------------------------------------------------- result check

  always @(posedge clk) begin : result_check
    beat_t want;
    if (!rst && result_valid) begin
      n_beats++;
      if (warning == W_OVERFLOW) n_overflow++;
      if (warning == W_UNKNOWN)  n_unknown++;
      if (warning == W_CHAIN)    n_chain++;
      if (!last)                 n_two++;
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: action %0d frame %0h", action, out_frame);
        fail_count++;
      end else begin
        want = pending_beats.pop_front();
        if (action !== want.act) begin
          $error("action: expected %0d, got %0d", want.act, action);
          fail_count++;
        end
        if (target !== want.tgt) begin
          $error("target: expected %0h, got %0h", want.tgt, target);
          fail_count++;
        end
        if (out_frame !== want.frm) begin
          $error("out_frame: expected %0h, got %0h", want.frm, out_frame);
          fail_count++;
        end
        if (warning !== want.warn) begin
          $error("warning: expected %0d, got %0d", want.warn, warning);
          fail_count++;
        end
        if (last !== want.fin) begin
          $error("last: expected %0b, got %0b", want.fin, last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    int                 idle_pct;
    int                 roll;
    int                 n;
    logic [COUNT_W-1:0] r_cnt;
    logic [POLICY_W-1:0] r_pol;
    logic [TARGET_W-1:0] r_tgt;
    logic [3:0]         r_mask;
    logic               r_cmd;
    logic [FRAME_W-1:0] r_frm;
    logic [FRAME_W-1:0] in_flight [$];
    beat_t              none;

    none      = '0;
    rst       <= 1'b1;
    start     <= 1'b0;
    cmd       <= CMD_NEW;
    frame_id  <= '0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_STAGE_COUNT;
    cfg_data  <= '0;

    reg_count    = '0;
    reg_policies = '0;
    reg_targets  = '0;
    chain_valid  = 1'b0;
    for (int i = 0; i < STAGES; i++) begin
      slot_busy[i] = 1'b0;
      fifo_fill[i] = 0;
    end

    // Unconfigured chain, then a wait / drop-oldest / no-reply chain
    plan_typed(CMD_NEW,    8'h00, ACT_WARN,    4'h0, W_CHAIN);
    plan_typed(CMD_NEW,    8'hFF, ACT_WARN,    4'h0, W_CHAIN);
    plan_typed(CMD_RETURN, 8'h5A, ACT_RELEASE, 4'h0, W_UNKNOWN);
    plan_setup(4'b1111, 4'd3, 16'h0036, 32'h0000_0FA5);
    plan_typed(CMD_NEW,    8'h10, ACT_DISPATCH, 4'h5, W_NONE);
    plan_item(CMD_NEW, 8'h11);
    plan_item(CMD_NEW, 8'h12);
    plan_item(CMD_NEW, 8'h13);
    plan_item(CMD_NEW, 8'h14);
    plan_typed(CMD_NEW,    8'h15, ACT_RELEASE, 4'h0, W_OVERFLOW);
    plan_item(CMD_RETURN, 8'h10);
    plan_typed(CMD_RETURN, 8'h77, ACT_RELEASE, 4'h0, W_UNKNOWN);
    plan_item(CMD_RETURN, 8'h11);
    plan_item(CMD_RETURN, 8'h12);
    plan_item(CMD_RETURN, 8'h13);
    plan_item(CMD_RETURN, 8'h14);
    // drop-oldest with a full queue, then the no-reply tail and release
    plan_item(CMD_NEW,    8'hA0);
    plan_item(CMD_RETURN, 8'hA0);
    plan_item(CMD_RETURN, 8'h10);
    plan_item(CMD_RETURN, 8'h12);
    plan_item(CMD_RETURN, 8'h12);
    // count above STAGES, drop policy, all-ones targets
    plan_setup(4'b0111, 4'd15, 16'h0000, 32'hFFFF_FFFF);
    plan_typed(CMD_NEW,    8'hFF, ACT_DISPATCH, 4'hF, W_NONE);
    plan_typed(CMD_NEW,    8'h00, ACT_RELEASE,  4'h0, W_NONE);
    // no-reply in the middle breaks the chain, as does a zero count
    plan_setup(4'b0010, 4'd0, 16'hFFFF, 32'h0);
    plan_typed(CMD_NEW,    8'h42, ACT_WARN,    4'h0, W_CHAIN);
    plan_setup(4'b0001, 4'd0, 16'h0, 32'h0);
    plan_typed(CMD_RETURN, 8'h42, ACT_RELEASE, 4'h0, W_UNKNOWN);
    // single no-reply stage is a valid chain
    plan_setup(4'b0011, 4'd1, 16'hFFFF, 32'h0);
    plan_typed(CMD_NEW,    8'h33, ACT_DISPATCH, 4'hF, W_NONE);
    plan_item(CMD_NEW, 8'h34);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[p]) begin
      if (plan[p].is_setup) program_chain(plan[p].mask, plan[p].cnt, plan[p].pol, plan[p].tgt);
      else issue_event(plan[p].cmd, plan[p].frm, plan[p].typed, plan[p].want);
    end

    // Random part: mostly valid chains, returns mostly of frames in flight
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 15 : (phase == 1) ? 63 : 0;
      for (int seg = 0; seg < 8; seg++) begin
        if ($urandom_range(0, 9) == 0) r_cnt = COUNT_W'($urandom_range(0, 15));
        else r_cnt = COUNT_W'($urandom_range(1, STAGES));
        r_pol = POLICY_W'($urandom());
        r_tgt = $urandom();
        n = (r_cnt > STAGES) ? STAGES : int'(r_cnt);
        if ($urandom_range(0, 9) < 8)
          for (int i = 0; i + 1 < n; i++)
            if (r_pol[2*i +: 2] == POL_NO_REPLY) r_pol[2*i +: 2] = 2'($urandom_range(0, 2));
        r_mask = ($urandom_range(0, 7) == 0) ? 4'b1111 : 4'b0111;
        program_chain(r_mask, r_cnt, r_pol, r_tgt);

        for (int k = 0; k < 52; k++) begin
          in_flight.delete();
          for (int i = 0; i < live_stages(); i++)
            if (slot_busy[i]) in_flight.push_back(slot_frame[i]);
          r_frm = FRAME_W'($urandom());
          if ($urandom_range(0, 99) < 45) begin
            r_cmd = CMD_NEW;
          end else begin
            r_cmd = CMD_RETURN;
            if (in_flight.size() > 0 && $urandom_range(0, 99) < 85)
              r_frm = in_flight[$urandom_range(0, in_flight.size() - 1)];
          end
          issue_event(r_cmd, r_frm, 1'b0, none);

          roll = $urandom_range(0, 99);
          if (roll < 2) begin
            // hold off until every beat is out
            start <= 1'b0;
            @(posedge clk);
            while (pending_beats.size() != 0) @(posedge clk);
          end else if (roll < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
          end
        end
      end
    end

    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d frame events across %0d register setups; %0d result beats checked.",
             n_events, n_setups, n_beats);
    $display("Seen: %0d overflow releases, %0d unknown returns, %0d chain warnings,",
             n_overflow, n_unknown, n_chain);
    $display("      %0d two-beat events.", n_two);
    if (fail_count == 0) begin
      $display("** frame_stage_dispatcher: PASSED **");
    end else begin
      $display("** frame_stage_dispatcher: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("** frame_stage_dispatcher: FAILED **");
    $finish;
  end

endmodule

// ----- frame_stage_dispatcher.f -----
design/fsd_pkg.sv
design/fsd_ctrl.sv
design/fsd_datapath.sv
design/frame_stage_dispatcher.sv
tb/sv/tb_frame_stage_dispatcher.sv
